[design/scec_pkg.sv]
`timescale 1ns / 1ps

package scec_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int SUM_W     = 64;
   localparam int SCALE_W   = 32;
   localparam int RESULT_W  = 64;
   localparam int DIGIT_W   = 3;
   localparam int PROD_W    = SUM_W + SCALE_W;
   localparam int TOL_SHIFT = 16;

   // register map of the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE  = 2'd1;

   localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 32'd65536;
   localparam logic [SCALE_W-1:0] TOLERANCE_RESET  = 32'd1;

   // results that may be in flight between the accumulator and the port
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIGIT_W-1:0] DIGIT_LAST = 3'd4;

   localparam logic [RESULT_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [RESULT_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

   typedef logic [DIGIT_W-1:0] digit_type;

   // one finished box, handed from the accumulator to the finishing pipe
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] fine;
      logic [SUM_W-1:0] coarse;
   } box_sums_type;

   // one result, handed from the finishing pipe to the output queue
   typedef struct packed {
      logic                valid;
      logic [RESULT_W-1:0] integral;
      logic                not_converged;
   } result_type;

   // Simpson weights 1,4,2,4,1 as shift amounts
   function automatic logic [1:0] fine_shift(input digit_type g);
      logic [1:0] s;
      case (g)
         3'd1, 3'd3: s = 2'd2;
         3'd2:       s = 2'd1;
         default:    s = 2'd0;
      endcase
      return s;
   endfunction

   // coarse weights 1,0,4,0,1: shift amount for the nodes that are used
   function automatic logic [1:0] coarse_shift(input digit_type g);
      logic [1:0] s;
      case (g)
         3'd2:    s = 2'd2;
         default: s = 2'd0;
      endcase
      return s;
   endfunction

   function automatic logic coarse_used(input digit_type g);
      logic u;
      case (g)
         3'd1, 3'd3: u = 1'b0;
         default:    u = 1'b1;
      endcase
      return u;
   endfunction

endpackage

[design/simpson_cubature_error_check.sv]
`timescale 1ns / 1ps

// Tensor-product Simpson cubature over one box with a convergence check.
// Send the integrand samples of the 5^DIMENSIONS grid nodes of a box, one
// transaction each, in node order with the last dimension fastest. After the
// last node of a box one result transaction carries the fine integral
// (signed Q32.32, saturated) and not_converged, which is set when the fine
// and coarse (every other node) integrals differ by more than tolerance.
// The block takes one sample per cycle while not stalled and keeps accepting
// while results wait at the output; the first node of the next box may follow
// the last node of the previous one directly. After the edge that accepts the
// last sample of a box, the result passes the sample register, the shift-add
// accumulators, the finishing pipe (difference, magnitude, 32x32 partial
// products, product sum, saturation and compare) and the result queue write
// before rsp_valid rises. A two-entry result queue decouples the output; the
// input stalls only while the last node of a box is held because two earlier
// results are still undelivered.
// Write step_scale and tolerance through the csr_ port only while the block
// is idle; csr_ready is always high and unknown indexes are ignored.

module simpson_cubature_error_check #(
   parameter int DIMENSIONS = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [scec_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [scec_pkg::RESULT_W-1:0]  rsp_integral,
   output logic                                  rsp_not_converged,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scec_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [scec_pkg::SCALE_W-1:0]          csr_wdata
);
   import scec_pkg::*;

   logic [SCALE_W-1:0] step_scale_ff, tolerance_ff;
   logic               room, launch;
   box_sums_type       box_sums;
   result_type         result;

   // accept every write; drop unknown indexes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_scale_ff <= STEP_SCALE_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_SCALE: step_scale_ff <= csr_wdata;
            CSR_TOLERANCE:  tolerance_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // node counter, shift weights and both running sums
   scec_accum #(
      .DIMENSIONS (DIMENSIONS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .room       (room),
      .launch     (launch),
      .box_out    (box_sums)
   );

   // scale, saturate and compare one finished box
   scec_finish #(
      .DIMENSIONS (DIMENSIONS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .box_in     (box_sums),
      .step_scale (step_scale_ff),
      .tolerance  (tolerance_ff),
      .result     (result)
   );

   // hold results until the receiver takes them
   scec_out_queue u_out_queue (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .launch            (launch),
      .room              (room),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_integral      (rsp_integral),
      .rsp_not_converged (rsp_not_converged)
   );

endmodule

[design/scec_accum.sv]
`timescale 1ns / 1ps

module scec_accum #(
   parameter int DIMENSIONS = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [scec_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   room,
   output logic                                   launch,
   output scec_pkg::box_sums_type                 box_out
);
   import scec_pkg::*;

   localparam int SHIFT_W = $clog2(2 * DIMENSIONS + 1);

   digit_type digits_ff [DIMENSIONS];
   digit_type digits_in [DIMENSIONS];

   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SHIFT_W-1:0]  fsh_ff, fsh_in;
   logic [SHIFT_W-1:0]  csh_ff, csh_in;
   logic                cuse_ff, cuse_in;
   logic                last_ff, last_in;

   logic [SUM_W-1:0] fine_sum_ff, fine_sum_in;
   logic [SUM_W-1:0] coarse_sum_ff, coarse_sum_in;
   logic [SUM_W-1:0] fine_next, coarse_next, sample_ext;
   box_sums_type     box_ff, box_in;

   logic accept, advance;

   // advance the stage unless it holds the last node and no result slot is free
   assign advance   = valid_ff && (!last_ff || room);
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign launch    = advance && last_ff;
   assign box_out   = box_ff;

   // weights and base-5 increment, last dimension fastest
   always_comb begin
      logic carry;
      carry   = 1'b1;
      fsh_in  = '0;
      csh_in  = '0;
      cuse_in = 1'b1;
      last_in = 1'b1;
      for (int d = 0; d < DIMENSIONS; d++) begin
         fsh_in = fsh_in + SHIFT_W'(fine_shift(digits_ff[d]));
         csh_in = csh_in + SHIFT_W'(coarse_shift(digits_ff[d]));
         if (!coarse_used(digits_ff[d])) cuse_in = 1'b0;
         if (digits_ff[d] != DIGIT_LAST) last_in = 1'b0;
      end
      for (int d = DIMENSIONS - 1; d >= 0; d--) begin
         digits_in[d] = digits_ff[d];
         if (carry) begin
            if (digits_ff[d] == DIGIT_LAST) begin
               digits_in[d] = '0;
            end else begin
               digits_in[d] = digits_ff[d] + 3'd1;
               carry        = 1'b0;
            end
         end
      end
   end

   always_comb begin
      sample_ext  = {{(SUM_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      fine_next   = fine_sum_ff + (sample_ext << fsh_ff);
      coarse_next = cuse_ff ? coarse_sum_ff + (sample_ext << csh_ff) : coarse_sum_ff;

      valid_in      = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
      fine_sum_in   = fine_sum_ff;
      coarse_sum_in = coarse_sum_ff;
      box_in.valid  = 1'b0;
      box_in.fine   = fine_next;
      box_in.coarse = coarse_next;
      if (advance) begin
         if (last_ff) begin
            fine_sum_in   = '0;
            coarse_sum_in = '0;
            box_in.valid  = 1'b1;
         end else begin
            fine_sum_in   = fine_next;
            coarse_sum_in = coarse_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         fine_sum_ff   <= '0;
         coarse_sum_ff <= '0;
         box_ff.valid  <= 1'b0;
         for (int d = 0; d < DIMENSIONS; d++) digits_ff[d] <= '0;
      end else begin
         valid_ff      <= valid_in;
         fine_sum_ff   <= fine_sum_in;
         coarse_sum_ff <= coarse_sum_in;
         box_ff        <= box_in;
         if (accept) begin
            for (int d = 0; d < DIMENSIONS; d++) digits_ff[d] <= digits_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         fsh_ff    <= fsh_in;
         csh_ff    <= csh_in;
         cuse_ff   <= cuse_in;
         last_ff   <= last_in;
      end
   end

endmodule

[design/scec_finish.sv]
`timescale 1ns / 1ps

module scec_finish #(
   parameter int DIMENSIONS = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  scec_pkg::box_sums_type           box_in,
   input  logic [scec_pkg::SCALE_W-1:0]     step_scale,
   input  logic [scec_pkg::SCALE_W-1:0]     tolerance,
   output scec_pkg::result_type             result
);
   import scec_pkg::*;

   // difference stage
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_fine_ff, s2_diff_ff;
   // magnitude stage
   logic             s3_valid_ff, s3_neg_ff;
   logic [SUM_W-1:0] s3_mag_f_ff, s3_mag_d_ff;
   // partial products
   logic             s4_valid_ff, s4_neg_ff;
   logic [63:0]      s4_pf0_ff, s4_pf1_ff, s4_pd0_ff, s4_pd1_ff;
   // full products
   logic              s5_valid_ff, s5_neg_ff;
   logic [PROD_W-1:0] s5_pf_ff, s5_pd_ff;

   logic [SUM_W-1:0]    diff_in, mag_f_in, mag_d_in;
   logic [63:0]         pf0_in, pf1_in, pd0_in, pd1_in;
   logic [PROD_W-1:0]   pf_in, pd_in;
   logic [RESULT_W-1:0] integral_in;
   logic [SUM_W-1:0]    tol_wide;
   logic                flag_in;
   result_type          result_ff;

   assign result = result_ff;

   assign diff_in  = box_in.fine - (box_in.coarse << DIMENSIONS);
   assign mag_f_in = s2_fine_ff[SUM_W-1] ? SUM_W'(0) - s2_fine_ff : s2_fine_ff;
   assign mag_d_in = s2_diff_ff[SUM_W-1] ? SUM_W'(0) - s2_diff_ff : s2_diff_ff;

   assign pf0_in = 64'(s3_mag_f_ff[31:0])  * 64'(step_scale);
   assign pf1_in = 64'(s3_mag_f_ff[63:32]) * 64'(step_scale);
   assign pd0_in = 64'(s3_mag_d_ff[31:0])  * 64'(step_scale);
   assign pd1_in = 64'(s3_mag_d_ff[63:32]) * 64'(step_scale);

   assign pf_in = {32'd0, s4_pf0_ff} + {s4_pf1_ff, 32'd0};
   assign pd_in = {32'd0, s4_pd0_ff} + {s4_pd1_ff, 32'd0};

   assign tol_wide = {16'd0, tolerance, 16'd0};

   // saturate the fine integral, compare the difference against the tolerance
   always_comb begin
      if (!s5_neg_ff) begin
         integral_in = (s5_pf_ff[PROD_W-1:SUM_W] != '0 || s5_pf_ff[SUM_W-1])
                       ? SAT_POS : s5_pf_ff[SUM_W-1:0];
      end else begin
         integral_in = (s5_pf_ff[PROD_W-1:SUM_W] != '0 || s5_pf_ff[SUM_W-1:0] > SAT_NEG)
                       ? SAT_NEG : RESULT_W'(0) - s5_pf_ff[SUM_W-1:0];
      end
      flag_in = (s5_pd_ff[PROD_W-1:SUM_W] != '0) || (s5_pd_ff[SUM_W-1:0] > tol_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         s5_valid_ff     <= 1'b0;
         result_ff.valid <= 1'b0;
      end else begin
         s2_valid_ff             <= box_in.valid;
         s3_valid_ff             <= s2_valid_ff;
         s4_valid_ff             <= s3_valid_ff;
         s5_valid_ff             <= s4_valid_ff;
         result_ff.valid         <= s5_valid_ff;
         result_ff.integral      <= integral_in;
         result_ff.not_converged <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_fine_ff              <= box_in.fine;
      s2_diff_ff              <= diff_in;
      s3_neg_ff               <= s2_fine_ff[SUM_W-1];
      s3_mag_f_ff             <= mag_f_in;
      s3_mag_d_ff             <= mag_d_in;
      s4_neg_ff               <= s3_neg_ff;
      s4_pf0_ff               <= pf0_in;
      s4_pf1_ff               <= pf1_in;
      s4_pd0_ff               <= pd0_in;
      s4_pd1_ff               <= pd1_in;
      s5_neg_ff               <= s4_neg_ff;
      s5_pf_ff                <= pf_in;
      s5_pd_ff                <= pd_in;
   end

endmodule

[design/scec_out_queue.sv]
`timescale 1ns / 1ps

module scec_out_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  scec_pkg::result_type                 result,
   input  logic                                 launch,
   output logic                                 room,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [scec_pkg::RESULT_W-1:0] rsp_integral,
   output logic                                 rsp_not_converged
);
   import scec_pkg::*;

   logic [RESULT_W-1:0] integral_ff [QUEUE_DEPTH];
   logic                flag_ff     [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   level_ff, level_in;
   logic [QCNT_W-1:0]   inflight_ff, inflight_in;
   logic                pop;

   assign rsp_valid         = level_ff != '0;
   assign pop               = rsp_valid && !rsp_stall;
   assign room              = inflight_ff != QCNT_W'(QUEUE_DEPTH);
   assign rsp_integral      = integral_ff[rd_ptr_ff];
   assign rsp_not_converged = flag_ff[rd_ptr_ff];

   // count results from launch to delivery so the queue can never overflow
   always_comb begin
      inflight_in = inflight_ff + QCNT_W'(launch) - QCNT_W'(pop);
      level_in    = level_ff + QCNT_W'(result.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         level_ff    <= '0;
         inflight_ff <= '0;
      end else begin
         level_ff    <= level_in;
         inflight_ff <= inflight_in;
         if (result.valid) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)          rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         integral_ff[wr_ptr_ff] <= result.integral;
         flag_ff[wr_ptr_ff]     <= result.not_converged;
      end
   end

endmodule
